FILE: sv/tsi_pkg.sv
// tsi_pkg: shared types and constants for the trie string interner.
// Holds command and status codes, sequencer states and parameter defaults.
// No dependencies.
package tsi_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int MAX_LEN_DEF    = 64;

    localparam logic CMD_INTERN = 1'b0;
    localparam logic CMD_GET    = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ILOOK,
        S_GREAD,
        S_GEMIT
    } t_state;

    typedef enum logic [1:0] {
        ALU_WALK,
        ALU_QUERY,
        ALU_LEN
    } t_alu_sel;

endpackage

FILE: sv/tsi_ram.sv
// tsi_ram: generic simple dual-port RAM, one write port and one read port.
// Read data is registered. No dependencies.
module tsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tsi_alu.sv
// tsi_alu: shared compare and increment unit used by the sequencer steps.
// Compares node numbers, query nodes and the get length. No dependencies.
module tsi_alu #(
    parameter int CW = 17
) (
    input  logic [CW-1:0] i_a,
    input  logic [CW-1:0] i_b,
    input  logic [CW-1:0] i_c,
    output logic          o_ge,
    output logic [CW-1:0] o_inc
);

    assign o_ge  = (i_a >= i_b);
    assign o_inc = i_c + CW'(1);

endmodule

FILE: sv/trie_string_interner.sv
// trie_string_interner: top level, sequencer plus child table and back link memories.
// Depends on tsi_pkg, tsi_ram and tsi_alu.
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+-----------------------------------------------------
//  in      | i_valid  | o_stall   | i_cmd, i_char_byte, i_last_byte, i_query_index
//  out     | o_valid  | i_stall   | o_result_index, o_out_byte, o_end_of_run, o_status
//
// Intern byte: accept, then child table read in S_ILOOK; a final byte skips S_ILOOK,
// and so does any byte of a string that already failed or fails on it.
// Get: an invalid index is answered at accept; else a back link read per emitted byte.
// After reset the child table is swept clear, all NODE_COUNT*256 entries, with o_stall high.
// One item is in work at a time; the output register frees the input side once taken.
// A stall on the output holds the result and keeps o_stall high until it is taken.
module trie_string_interner import tsi_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int MAX_LEN    = MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_query_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_index,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_run,
    output logic [1:0]  o_status
);

    localparam int NB    = $clog2(NODE_COUNT);
    localparam int AW    = NB + 8;
    localparam int DEPTH = NODE_COUNT * 256;
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int CW    = NB + 9;
    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [NB:0]   USED_FULL = (NB + 1)'(NODE_COUNT);

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [NB:0]   r_used, n_used;
    logic [NB-1:0] r_walk_node, n_walk_node;
    logic          r_walk_none, n_walk_none;
    logic [AW-1:0] r_widx, n_widx;
    logic          r_widx_none, n_widx_none;
    logic          r_failed, n_failed;
    logic [15:0]   r_gq, n_gq;
    logic [AW-1:0] r_gidx, n_gidx;
    logic [LW-1:0] r_n, n_n;
    logic          r_ovld, n_ovld;
    logic [15:0]   r_oidx, n_oidx;
    logic [7:0]    r_obyte, n_obyte;
    logic          r_oend, n_oend;
    logic [1:0]    r_ostat, n_ostat;

    logic          c_we, c_re;
    logic [AW-1:0] c_waddr, c_raddr;
    logic [NB:0]   c_wdata, c_rdata;
    logic          p_we, p_re;
    logic [NB-1:0] p_waddr, p_raddr;
    logic [AW:0]   p_wdata, p_rdata;

    t_alu_sel      alu_sel;
    logic [CW-1:0] alu_a, alu_b, alu_c, alu_inc;
    logic          alu_ge;

    logic          out_free, accept, full, need, alloc_fail, fail_eff;
    logic          next_none, g_end;
    logic [NB-1:0] blk;
    logic [AW-1:0] new_idx, q_idx;
    logic [31:0]   new_wide, q_wide;

    tsi_ram #(.WIDTH(NB + 1), .DEPTH(DEPTH)) u_child (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    tsi_ram #(.WIDTH(AW + 1), .DEPTH(NODE_COUNT)) u_link (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    tsi_alu #(.CW(CW)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .o_ge  (alu_ge),
        .o_inc (alu_inc)
    );

    assign alu_sel = (r_state == S_GEMIT) ? ALU_LEN :
                     ((r_state == S_IDLE) && (i_cmd == CMD_GET)) ? ALU_QUERY : ALU_WALK;

    always_comb begin
        unique case (alu_sel)
            ALU_WALK: begin
                alu_a = CW'(r_walk_node);
                alu_b = CW'(r_used);
                alu_c = CW'(r_used);
            end
            ALU_QUERY: begin
                alu_a = CW'(i_query_index[15:8]);
                alu_b = CW'(r_used);
                alu_c = CW'(r_used);
            end
            ALU_LEN: begin
                alu_a = CW'(r_n);
                alu_b = CW'(MAX_LEN - 1);
                alu_c = CW'(r_n);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
                alu_c = '0;
            end
        endcase
    end

    assign out_free   = !r_ovld || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && out_free);
    assign accept     = i_valid && !o_stall;
    assign full       = (r_used == USED_FULL);
    assign need       = r_walk_none || alu_ge;
    assign alloc_fail = need && full;
    assign fail_eff   = r_failed || alloc_fail;
    assign blk        = need ? r_used[NB-1:0] : r_walk_node;
    assign new_idx    = {blk, i_char_byte};
    assign new_wide   = 32'(new_idx);
    assign q_wide     = 32'(i_query_index);
    assign q_idx      = q_wide[AW-1:0];
    assign next_none  = p_rdata[AW];
    assign g_end      = next_none || alu_ge;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_GET) begin
                        if (!alu_ge) n_state = S_GREAD;
                    end else if (!i_last_byte && !fail_eff) begin
                        n_state = S_ILOOK;
                    end
                end
            end
            S_ILOOK: n_state = S_IDLE;
            S_GREAD: n_state = S_GEMIT;
            S_GEMIT: begin
                if (out_free) n_state = g_end ? S_IDLE : S_GREAD;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // memory controls
    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_clr;
        c_wdata = '0;
        c_re    = 1'b0;
        c_raddr = new_idx;
        p_we    = 1'b0;
        p_waddr = blk;
        p_wdata = {r_widx_none, r_widx};
        p_re    = 1'b0;
        p_raddr = r_gidx[AW-1:8];
        unique case (r_state)
            S_CLEAR: c_we = 1'b1;
            S_IDLE: begin
                if (accept && (i_cmd == CMD_INTERN) && !fail_eff) begin
                    c_re = 1'b1;
                    if (need) begin
                        p_we = 1'b1;
                        // link the parent entry to the new node
                        if (!r_widx_none) begin
                            c_we    = 1'b1;
                            c_waddr = r_widx;
                            c_wdata = {1'b1, blk};
                        end
                    end
                end
            end
            S_GREAD: p_re = 1'b1;
            S_ILOOK, S_GEMIT: ;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_clr       = r_clr;
        n_used      = r_used;
        n_walk_node = r_walk_node;
        n_walk_none = r_walk_none;
        n_widx      = r_widx;
        n_widx_none = r_widx_none;
        n_failed    = r_failed;
        n_gq        = r_gq;
        n_gidx      = r_gidx;
        n_n         = r_n;
        n_ovld      = r_ovld && i_stall;
        n_oidx      = r_oidx;
        n_obyte     = r_obyte;
        n_oend      = r_oend;
        n_ostat     = r_ostat;
        case (r_state)
            S_CLEAR: n_clr = r_clr + AW'(1);
            S_IDLE: begin
                if (accept && (i_cmd == CMD_INTERN)) begin
                    if (!r_failed) begin
                        if (alloc_fail) begin
                            n_failed = 1'b1;
                        end else begin
                            if (need) n_used = alu_inc[NB:0];
                            n_widx      = new_idx;
                            n_widx_none = 1'b0;
                        end
                    end
                    if (i_last_byte) begin
                        n_ovld      = 1'b1;
                        n_oidx      = fail_eff ? 16'd0 : new_wide[15:0];
                        n_obyte     = 8'd0;
                        n_oend      = 1'b1;
                        n_ostat     = fail_eff ? ST_FULL : ST_OK;
                        // restart the walk at the root
                        n_walk_node = '0;
                        n_walk_none = 1'b0;
                        n_widx_none = 1'b1;
                        n_failed    = 1'b0;
                    end
                end else if (accept) begin
                    if (alu_ge) begin
                        n_ovld  = 1'b1;
                        n_oidx  = i_query_index;
                        n_obyte = 8'd0;
                        n_oend  = 1'b1;
                        n_ostat = ST_BAD;
                    end else begin
                        n_gq   = i_query_index;
                        n_gidx = q_idx;
                        n_n    = '0;
                    end
                end
            end
            S_ILOOK: begin
                n_walk_none = !c_rdata[NB];
                n_walk_node = c_rdata[NB-1:0];
            end
            S_GEMIT: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_oidx  = r_gq;
                    n_obyte = r_gidx[7:0];
                    n_oend  = g_end;
                    n_ostat = (g_end && !next_none) ? ST_BAD : ST_OK;
                    n_gidx  = p_rdata[AW-1:0];
                    n_n     = alu_inc[LW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_walk_node <= '0;
            r_walk_none <= 1'b0;
            r_widx_none <= 1'b1;
            r_failed    <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_walk_node <= n_walk_node;
            r_walk_none <= n_walk_none;
            r_widx_none <= n_widx_none;
            r_failed    <= n_failed;
            r_ovld      <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx  <= n_widx;
        r_gq    <= n_gq;
        r_gidx  <= n_gidx;
        r_n     <= n_n;
        r_oidx  <= n_oidx;
        r_obyte <= n_obyte;
        r_oend  <= n_oend;
        r_ostat <= n_ostat;
    end

    assign o_valid        = r_ovld;
    assign o_result_index = r_oidx;
    assign o_out_byte     = r_obyte;
    assign o_end_of_run   = r_oend;
    assign o_status       = r_ostat;

endmodule

FILE: sv/tsi_checker.sv
// tsi_checker: port-level assertions for the trie string interner, bound to the top.
// Depends on tsi_pkg and trie_string_interner.
module tsi_checker import tsi_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_cmd,
    input logic [7:0]  i_char_byte,
    input logic        i_last_byte,
    input logic [15:0] i_query_index,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_result_index,
    input logic [7:0]  o_out_byte,
    input logic        o_end_of_run,
    input logic [1:0]  o_status
);

    // hold a stalled transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_index) && $stable(o_out_byte)
            && $stable(o_end_of_run) && $stable(o_status))
        else $error("stalled result changed");

    // clear pass blocks input right after reset, and no result is shown
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("block active after reset");

    // a get run in progress keeps the input side closed
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_run |-> o_stall)
        else $error("input open in the middle of a get run");

    // a failed intern carries a zero index and ends its item
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_end_of_run && (o_result_index == 16'd0)
            && (o_out_byte == 8'd0))
        else $error("malformed store-full result");

endmodule

bind trie_string_interner tsi_checker u_tsi_checker (.*);
